FILE: sv/tlfq_pkg.sv
// ----------------------------------------------------------------------------
// tlfq_pkg
// shared types, codes and reset values of the three-level feedback scheduler
// ----------------------------------------------------------------------------
package tlfq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int BurstBitsDef  = 16;

  localparam logic [4:0] SysBudgetRst = 5'd8;
  localparam logic [4:0] IaBudgetRst  = 5'd16;
  localparam logic [4:0] SliceRst     = 5'd7;
  localparam logic [4:0] BtBudgetRst  = 5'd30;
  localparam logic [5:0] SysTopRst    = 6'd5;
  localparam logic [5:0] IaTopRst     = 6'd10;
  localparam logic [5:0] BtTopRst     = 6'd15;

  localparam logic KindAdmit = 1'b0;

  typedef enum logic [2:0] {
    EV_ADMIT   = 3'd0,
    EV_REJECT  = 3'd1,
    EV_DONE    = 3'd2,
    EV_MOVE    = 3'd3,
    EV_PARTIAL = 3'd4,
    EV_IDLE    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    Q_SYS = 2'd0,
    Q_IA  = 2'd1,
    Q_BT  = 2'd2
  } queue_e;

  typedef enum logic [2:0] {
    CFG_SYS_BUDGET = 3'd0,
    CFG_IA_BUDGET  = 3'd1,
    CFG_SLICE      = 3'd2,
    CFG_BT_BUDGET  = 3'd3,
    CFG_SYS_TOP    = 3'd4,
    CFG_IA_TOP     = 3'd5,
    CFG_BT_TOP     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADMIT,
    ST_SYS_CHECK,
    ST_SYS_SCAN,
    ST_SYS_SERVE,
    ST_SYS_SHIFT,
    ST_PHASE_SEL,
    ST_IA_READ,
    ST_IA_SERVE,
    ST_BT_READ,
    ST_BT_SERVE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_tag;
    logic [15:0] burst_time;
    logic [5:0]  task_priority;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  task_id;
    logic [1:0]  from_queue;
    logic [1:0]  to_queue;
    logic [4:0]  ran_for;
    logic [15:0] remaining;
    logic        last;
  } out_item_t;

endpackage

FILE: sv/tlfq_ram.sv
// ----------------------------------------------------------------------------
// tlfq_ram
// task store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tlfq_ram #(
  parameter int DEPTH = tlfq_pkg::QueueDepthDef,
  parameter int WIDTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/three_level_feedback_queue_scheduler.sv
// admit: ST_ADMIT places the result in the holding stage, ST_FINISH moves it to the output and waits on output stalls
// round: per system event a check, a min scan over the system store, the serve,
//   then compaction of the system store; per interactive or batch event a read and a serve state
// one transaction in work at a time; results drain through a one-deep holding stage
// reset clears counts, pointers, control and configuration registers at once; stores need no clearing pass
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// three-queue scheduler with system priority queue, interactive round robin
// and batch fifo, state kept in three single-port-pair memories
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = tlfq_pkg::QueueDepthDef,
  parameter int BURST_BITS  = tlfq_pkg::BurstBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlfq_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlfq_pkg::out_item_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int EntW = 8 + BURST_BITS + 6;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  // configuration registers
  logic [4:0] sys_budget_q, ia_budget_q, slice_q, bt_budget_q;
  logic [5:0] sys_top_q, ia_top_q, bt_top_q;

  // control state
  tlfq_pkg::state_e state_q, state_d;
  tlfq_pkg::in_item_t item_q, item_d;
  logic [4:0]      time_q, time_d;
  logic [CntW-1:0] sys_cnt_q, sys_cnt_d;
  logic [IdxW-1:0] ia_head_q, ia_head_d, ia_tail_q, ia_tail_d;
  logic [CntW-1:0] ia_cnt_q, ia_cnt_d;
  logic [IdxW-1:0] bt_head_q, bt_head_d, bt_tail_q, bt_tail_d;
  logic [CntW-1:0] bt_cnt_q, bt_cnt_d;
  logic [CntW-1:0] live_q, live_d;
  logic [IdxW-1:0] scan_idx_q, scan_idx_d, best_idx_q, best_idx_d;
  logic [EntW-1:0] best_q, best_d;
  logic [CntW-1:0] shift_idx_q, shift_idx_d;

  // result holding stage and output register
  tlfq_pkg::out_item_t pend_q, pend_d, out_q, out_d;
  logic pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;

  // memory ports
  logic            sys_we, ia_we, bt_we;
  logic [IdxW-1:0] sys_waddr, ia_waddr, bt_waddr;
  logic [EntW-1:0] sys_wdata, ia_wdata, bt_wdata;
  logic [IdxW-1:0] sys_raddr, ia_raddr, bt_raddr;
  logic [EntW-1:0] sys_rdata, ia_rdata, bt_rdata;

  tlfq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EntW)) u_sys_ram (
    .clk_i, .we_i(sys_we), .waddr_i(sys_waddr), .wdata_i(sys_wdata),
    .raddr_i(sys_raddr), .rdata_o(sys_rdata)
  );
  tlfq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EntW)) u_ia_ram (
    .clk_i, .we_i(ia_we), .waddr_i(ia_waddr), .wdata_i(ia_wdata),
    .raddr_i(ia_raddr), .rdata_o(ia_rdata)
  );
  tlfq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EntW)) u_bt_ram (
    .clk_i, .we_i(bt_we), .waddr_i(bt_waddr), .wdata_i(bt_wdata),
    .raddr_i(bt_raddr), .rdata_o(bt_rdata)
  );

  // entry layout: tag, burst, priority
  function automatic logic [7:0] ent_tag(logic [EntW-1:0] e);
    return e[EntW-1 -: 8];
  endfunction
  function automatic logic [BURST_BITS-1:0] ent_burst(logic [EntW-1:0] e);
    return e[6 +: BURST_BITS];
  endfunction
  function automatic logic [5:0] ent_prio(logic [EntW-1:0] e);
    return e[5:0];
  endfunction
  function automatic logic [15:0] to_rem(logic [BURST_BITS-1:0] b);
    logic [31:0] w;
    w = 32'(b);
    return w[15:0];
  endfunction
  function automatic logic [IdxW-1:0] wrap_inc(logic [IdxW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_budget_q <= tlfq_pkg::SysBudgetRst;
      ia_budget_q  <= tlfq_pkg::IaBudgetRst;
      slice_q      <= tlfq_pkg::SliceRst;
      bt_budget_q  <= tlfq_pkg::BtBudgetRst;
      sys_top_q    <= tlfq_pkg::SysTopRst;
      ia_top_q     <= tlfq_pkg::IaTopRst;
      bt_top_q     <= tlfq_pkg::BtTopRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tlfq_pkg::CFG_SYS_BUDGET: sys_budget_q <= cfg_data_i[4:0];
        tlfq_pkg::CFG_IA_BUDGET:  ia_budget_q  <= cfg_data_i[4:0];
        tlfq_pkg::CFG_SLICE:      slice_q      <= cfg_data_i[4:0];
        tlfq_pkg::CFG_BT_BUDGET:  bt_budget_q  <= cfg_data_i[4:0];
        tlfq_pkg::CFG_SYS_TOP:    sys_top_q    <= cfg_data_i;
        tlfq_pkg::CFG_IA_TOP:     ia_top_q     <= cfg_data_i;
        tlfq_pkg::CFG_BT_TOP:     bt_top_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer: one transaction at a time; every event but the idle event passes the holding stage
  always_comb begin
    logic                out_free, emit_req, emit_ok;
    tlfq_pkg::out_item_t ev;
    logic [31:0]         wide_burst;
    logic [BURST_BITS-1:0] in_burst, p_burst, tz, sz;
    logic [EntW-1:0]     p;
    logic [4:0]          slice;
    logic [CntW-1:0]     nxt;

    state_d      = state_q;
    item_d       = item_q;
    time_d       = time_q;
    sys_cnt_d    = sys_cnt_q;
    ia_head_d    = ia_head_q;
    ia_tail_d    = ia_tail_q;
    ia_cnt_d     = ia_cnt_q;
    bt_head_d    = bt_head_q;
    bt_tail_d    = bt_tail_q;
    bt_cnt_d     = bt_cnt_q;
    live_d       = live_q;
    scan_idx_d   = scan_idx_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    shift_idx_d  = shift_idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    sys_we = 1'b0; sys_waddr = '0; sys_wdata = '0; sys_raddr = '0;
    ia_we  = 1'b0; ia_waddr  = ia_tail_q; ia_wdata = '0; ia_raddr = ia_head_q;
    bt_we  = 1'b0; bt_waddr  = bt_tail_q; bt_wdata = '0; bt_raddr = bt_head_q;

    out_free = !out_valid_q || !out_stall_i;
    emit_req = 1'b0;
    emit_ok  = !pend_valid_q || out_free;
    ev       = '0;

    wide_burst = 32'(item_q.burst_time);
    in_burst   = wide_burst[BURST_BITS-1:0];
    tz         = BURST_BITS'(time_q);
    slice      = (slice_q == 5'd0) ? 5'd1 : slice_q;
    sz         = BURST_BITS'(slice);
    p          = best_q;
    p_burst    = ent_burst(best_q);
    nxt        = '0;

    unique case (state_q)
      tlfq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_i;
          if (in_i.kind == tlfq_pkg::KindAdmit) begin
            state_d = tlfq_pkg::ST_ADMIT;
          end else begin
            time_d  = sys_budget_q;
            state_d = tlfq_pkg::ST_SYS_CHECK;
          end
        end
      end

      tlfq_pkg::ST_ADMIT: begin
        emit_req     = 1'b1;
        ev.task_id   = item_q.task_tag;
        ev.remaining = to_rem(in_burst);
        if (in_burst == '0 || item_q.task_priority > bt_top_q ||
            live_q == CntW'(QUEUE_DEPTH)) begin
          ev.event_res = tlfq_pkg::EV_REJECT;
        end else begin
          ev.event_res = tlfq_pkg::EV_ADMIT;
          if (item_q.task_priority <= sys_top_q) begin
            ev.from_queue = tlfq_pkg::Q_SYS;
            if (emit_ok) begin
              sys_we    = 1'b1;
              sys_waddr = sys_cnt_q[IdxW-1:0];
              sys_cnt_d = sys_cnt_q + 1'b1;
            end
          end else if (item_q.task_priority <= ia_top_q) begin
            ev.from_queue = tlfq_pkg::Q_IA;
            if (emit_ok) begin
              ia_we     = 1'b1;
              ia_tail_d = wrap_inc(ia_tail_q);
              ia_cnt_d  = ia_cnt_q + 1'b1;
            end
          end else begin
            ev.from_queue = tlfq_pkg::Q_BT;
            if (emit_ok) begin
              bt_we     = 1'b1;
              bt_tail_d = wrap_inc(bt_tail_q);
              bt_cnt_d  = bt_cnt_q + 1'b1;
            end
          end
          if (emit_ok) live_d = live_q + 1'b1;
        end
        ev.to_queue = ev.from_queue;
        sys_wdata = {item_q.task_tag, in_burst, item_q.task_priority};
        ia_wdata  = sys_wdata;
        bt_wdata  = sys_wdata;
        if (emit_ok) state_d = tlfq_pkg::ST_FINISH;
      end

      tlfq_pkg::ST_SYS_CHECK: begin
        if (time_q != 5'd0 && sys_cnt_q != '0) begin
          sys_raddr  = '0;
          scan_idx_d = '0;
          state_d    = tlfq_pkg::ST_SYS_SCAN;
        end else begin
          state_d = tlfq_pkg::ST_PHASE_SEL;
        end
      end

      // one entry a cycle, strict compare keeps the earliest of equal priorities
      tlfq_pkg::ST_SYS_SCAN: begin
        if (scan_idx_q == '0 || ent_prio(sys_rdata) < ent_prio(best_q)) begin
          best_d     = sys_rdata;
          best_idx_d = scan_idx_q;
        end
        nxt = CntW'(scan_idx_q) + 1'b1;
        if (nxt < sys_cnt_q) begin
          sys_raddr  = nxt[IdxW-1:0];
          scan_idx_d = nxt[IdxW-1:0];
        end else begin
          state_d = tlfq_pkg::ST_SYS_SERVE;
        end
      end

      tlfq_pkg::ST_SYS_SERVE: begin
        emit_req   = 1'b1;
        ev.task_id = ent_tag(p);
        ev.from_queue = tlfq_pkg::Q_SYS;
        if (p_burst <= tz) begin
          ev.event_res = tlfq_pkg::EV_DONE;
          ev.to_queue  = tlfq_pkg::Q_SYS;
          ev.ran_for   = p_burst[4:0];
          if (emit_ok) begin
            time_d = time_q - p_burst[4:0];
            live_d = live_q - 1'b1;
          end
        end else begin
          // overrun drops to interactive
          ev.event_res = tlfq_pkg::EV_MOVE;
          ev.to_queue  = tlfq_pkg::Q_IA;
          ev.ran_for   = time_q;
          ev.remaining = to_rem(p_burst - tz);
          ia_wdata     = {ent_tag(p), p_burst - tz, ent_prio(p)};
          if (emit_ok) begin
            ia_we     = 1'b1;
            ia_tail_d = wrap_inc(ia_tail_q);
            ia_cnt_d  = ia_cnt_q + 1'b1;
            time_d    = 5'd0;
          end
        end
        nxt = CntW'(best_idx_q) + 1'b1;
        if (emit_ok) begin
          shift_idx_d = nxt;
          if (nxt < sys_cnt_q) begin
            sys_raddr = nxt[IdxW-1:0];
            state_d   = tlfq_pkg::ST_SYS_SHIFT;
          end else begin
            sys_cnt_d = sys_cnt_q - 1'b1;
            state_d   = tlfq_pkg::ST_SYS_CHECK;
          end
        end
      end

      // compaction keeps arrival order for the tie rule
      tlfq_pkg::ST_SYS_SHIFT: begin
        sys_we    = 1'b1;
        sys_waddr = IdxW'(shift_idx_q - 1'b1);
        sys_wdata = sys_rdata;
        nxt = shift_idx_q + 1'b1;
        if (nxt < sys_cnt_q) begin
          sys_raddr   = nxt[IdxW-1:0];
          shift_idx_d = nxt;
        end else begin
          sys_cnt_d = sys_cnt_q - 1'b1;
          state_d   = tlfq_pkg::ST_SYS_CHECK;
        end
      end

      tlfq_pkg::ST_PHASE_SEL: begin
        if (sys_cnt_q == '0 && ia_cnt_q != '0) begin
          time_d  = ia_budget_q;
          state_d = tlfq_pkg::ST_IA_READ;
        end else if (sys_cnt_q == '0 && bt_cnt_q != '0) begin
          time_d  = bt_budget_q;
          state_d = tlfq_pkg::ST_BT_READ;
        end else begin
          state_d = tlfq_pkg::ST_FINISH;
        end
      end

      tlfq_pkg::ST_IA_READ: begin
        if (time_q != 5'd0 && ia_cnt_q != '0) state_d = tlfq_pkg::ST_IA_SERVE;
        else state_d = tlfq_pkg::ST_FINISH;
      end

      tlfq_pkg::ST_IA_SERVE: begin
        p          = ia_rdata;
        p_burst    = ent_burst(ia_rdata);
        emit_req   = 1'b1;
        ev.task_id = ent_tag(p);
        ev.from_queue = tlfq_pkg::Q_IA;
        ev.to_queue   = tlfq_pkg::Q_IA;
        bt_wdata = {ent_tag(p), p_burst - sz, ent_prio(p)};
        ia_waddr = ia_head_q;
        ia_wdata = {ent_tag(p), p_burst - tz, ent_prio(p)};
        priority if (p_burst <= sz && p_burst <= tz) begin
          ev.event_res = tlfq_pkg::EV_DONE;
          ev.ran_for   = p_burst[4:0];
          if (emit_ok) begin
            time_d    = time_q - p_burst[4:0];
            ia_head_d = wrap_inc(ia_head_q);
            ia_cnt_d  = ia_cnt_q - 1'b1;
            live_d    = live_q - 1'b1;
          end
        end else if (p_burst > sz && slice <= time_q) begin
          // slice used up, demote to batch
          ev.event_res = tlfq_pkg::EV_MOVE;
          ev.to_queue  = tlfq_pkg::Q_BT;
          ev.ran_for   = slice;
          ev.remaining = to_rem(p_burst - sz);
          if (emit_ok) begin
            time_d    = time_q - slice;
            ia_head_d = wrap_inc(ia_head_q);
            ia_cnt_d  = ia_cnt_q - 1'b1;
            bt_we     = 1'b1;
            bt_tail_d = wrap_inc(bt_tail_q);
            bt_cnt_d  = bt_cnt_q + 1'b1;
          end
        end else begin
          // budget ends inside the slice, remainder stays at the head
          ev.event_res = tlfq_pkg::EV_PARTIAL;
          ev.ran_for   = time_q;
          ev.remaining = to_rem(p_burst - tz);
          if (emit_ok) begin
            ia_we  = 1'b1;
            time_d = 5'd0;
          end
        end
        if (emit_ok) state_d = tlfq_pkg::ST_IA_READ;
      end

      tlfq_pkg::ST_BT_READ: begin
        if (time_q != 5'd0 && bt_cnt_q != '0) state_d = tlfq_pkg::ST_BT_SERVE;
        else state_d = tlfq_pkg::ST_FINISH;
      end

      tlfq_pkg::ST_BT_SERVE: begin
        p          = bt_rdata;
        p_burst    = ent_burst(bt_rdata);
        emit_req   = 1'b1;
        ev.task_id = ent_tag(p);
        ev.from_queue = tlfq_pkg::Q_BT;
        sys_waddr = sys_cnt_q[IdxW-1:0];
        sys_wdata = {ent_tag(p), p_burst - tz, ent_prio(p)};
        if (p_burst <= tz) begin
          ev.event_res = tlfq_pkg::EV_DONE;
          ev.to_queue  = tlfq_pkg::Q_BT;
          ev.ran_for   = p_burst[4:0];
          if (emit_ok) begin
            time_d = time_q - p_burst[4:0];
            live_d = live_q - 1'b1;
          end
        end else begin
          // overrun goes back to system
          ev.event_res = tlfq_pkg::EV_MOVE;
          ev.to_queue  = tlfq_pkg::Q_SYS;
          ev.ran_for   = time_q;
          ev.remaining = to_rem(p_burst - tz);
          if (emit_ok) begin
            sys_we    = 1'b1;
            sys_cnt_d = sys_cnt_q + 1'b1;
            time_d    = 5'd0;
          end
        end
        if (emit_ok) begin
          bt_head_d = wrap_inc(bt_head_q);
          bt_cnt_d  = bt_cnt_q - 1'b1;
          state_d   = tlfq_pkg::ST_BT_READ;
        end
      end

      // held event goes out marked last, or an idle event if none came
      tlfq_pkg::ST_FINISH: begin
        if (out_free) begin
          if (pend_valid_q) begin
            out_d = pend_q;
          end else begin
            out_d = '0;
            out_d.event_res = tlfq_pkg::EV_IDLE;
          end
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = tlfq_pkg::ST_IDLE;
        end
      end

      default: state_d = tlfq_pkg::ST_IDLE;
    endcase

    // a new event pushes the held one out, not last
    if (emit_req && emit_ok) begin
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_d.last  = 1'b0;
        out_valid_d = 1'b1;
      end
      pend_d       = ev;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tlfq_pkg::ST_IDLE;
      time_q       <= '0;
      sys_cnt_q    <= '0;
      ia_head_q    <= '0;
      ia_tail_q    <= '0;
      ia_cnt_q     <= '0;
      bt_head_q    <= '0;
      bt_tail_q    <= '0;
      bt_cnt_q     <= '0;
      live_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      sys_cnt_q    <= sys_cnt_d;
      ia_head_q    <= ia_head_d;
      ia_tail_q    <= ia_tail_d;
      ia_cnt_q     <= ia_cnt_d;
      bt_head_q    <= bt_head_d;
      bt_tail_q    <= bt_tail_d;
      bt_cnt_q     <= bt_cnt_d;
      live_q       <= live_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    scan_idx_q  <= scan_idx_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    shift_idx_q <= shift_idx_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != tlfq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // between transactions every live task sits in exactly one queue
  a_idle_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tlfq_pkg::ST_IDLE |->
      ((CntW+2)'(sys_cnt_q) + (CntW+2)'(ia_cnt_q) + (CntW+2)'(bt_cnt_q))
        == (CntW+2)'(live_q))
    else $error("queue counts disagree with live task count");

  a_live_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(QUEUE_DEPTH))
    else $error("live task count above queue depth");

  a_pend_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tlfq_pkg::ST_IDLE |-> !pend_valid_q)
    else $error("held event left behind at end of transaction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != tlfq_pkg::ST_IDLE)
    else $error("accepted transaction not started");
`endif

endmodule
